>>> rtl/llint_pkg.sv
// ----------------------------------------------------------------------------
// Limit-line interpolator package
// Shared constants, codes and the control token that walks the cell chain.
// ----------------------------------------------------------------------------
package llint_pkg;

  localparam int LEVEL_W  = 16;
  localparam int MODE_W   = 2;
  localparam int LOG_FRAC = 16;
  localparam int FRAC_W   = 17;
  localparam int PC_W     = 5;

  // Request kinds on the input tuser.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  // Segment interpolation modes.
  localparam logic [MODE_W-1:0] MODE_LOG  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LIN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP = 2'd2;

  // Register indexes.
  localparam int REG_POINT_COUNT = 0;

  typedef struct packed {
    logic below;
    logic above;
    logic hi_found;
  } chain_ctl_t;

endpackage

>>> rtl/limit_line_interpolator.sv
// ----------------------------------------------------------------------------
// Limit-line interpolator
// Breakpoint table in a chain of cells; log, linear or step interpolation.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                  Content
//  s_*      in   s_tvalid / s_tready        write entry or evaluate request
//  m_*      out  m_tvalid / m_tready        limit level and covered flag
//  APB      in   psel, penable, pwrite      point_count register
//
//  A write item is stored in its cell. An evaluation walks the query through
//  all MAX_POINTS cells, then for linear segments runs the divider, and for
//  log segments first runs three log2 passes and then the divider. A multiply
//  state and a saturating sum state follow. One item is in work at a time; a
//  held result blocks input.
//  Reset is synchronous and clears point_count; table entries start unknown.
// ----------------------------------------------------------------------------
module limit_line_interpolator #(
  parameter int MAX_POINTS = 16,
  parameter int FREQ_BITS  = 34
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // entry_index, entry_freq, entry_level, entry_mode, query_freq
  input  logic [((2*FREQ_BITS+22+7)/8)*8-1:0] s_tdata,
  // req_type
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // limit_level
  output logic [15:0]          m_tdata,
  // covered
  output logic                 m_tuser,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int EW  = $clog2(FREQ_BITS);
  localparam int LW  = EW + llint_pkg::LOG_FRAC;
  localparam int SPW = (FREQ_BITS > LW) ? FREQ_BITS : LW;
  localparam int LV  = llint_pkg::LEVEL_W;

  localparam int F_IDX  = 0;
  localparam int F_FREQ = 4;
  localparam int F_LVL  = F_FREQ + FREQ_BITS;
  localparam int F_MODE = F_LVL + LV;
  localparam int F_Q    = F_MODE + llint_pkg::MODE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CHAIN, S_LLO, S_LHI, S_LQ, S_DIV, S_MUL, S_SUM, S_OUT
  } state_t;

  state_t                       state;
  logic [llint_pkg::PC_W-1:0]   point_count;
  logic [NW-1:0]                n;
  logic [NW-1:0]                cnt;
  logic [FREQ_BITS-1:0]         q_reg;
  logic [FREQ_BITS-1:0]         flo_r;
  logic [FREQ_BITS-1:0]         fhi_r;
  logic signed [LV-1:0]         lo_r;
  logic signed [LV-1:0]         hi_r;
  logic [LW-1:0]                llo;
  logic [LW-1:0]                lhi;
  logic [SPW-1:0]               num;
  logic [SPW-1:0]               span;
  logic [llint_pkg::FRAC_W-1:0] frac;
  logic signed [34:0]           prod;
  logic signed [16:0]           diff;
  logic signed [19:0]           sum;
  logic                         log_go;
  logic [FREQ_BITS-1:0]         log_x;
  logic                         log_done;
  logic [LW-1:0]                log_res;
  logic                         div_go;
  logic                         div_done;
  logic [llint_pkg::FRAC_W-1:0] div_quot;
  logic                         wr_item;
  logic [6:0]                   pc_ext;

  logic [FREQ_BITS-1:0]         c_q   [MAX_POINTS+1];
  logic [FREQ_BITS-1:0]         c_flo [MAX_POINTS+1];
  logic [FREQ_BITS-1:0]         c_fhi [MAX_POINTS+1];
  logic signed [LV-1:0]         c_lo  [MAX_POINTS+1];
  logic signed [LV-1:0]         c_hi  [MAX_POINTS+1];
  logic [llint_pkg::MODE_W-1:0] c_mode[MAX_POINTS+1];
  llint_pkg::chain_ctl_t        c_ctl [MAX_POINTS+1];

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr == 3'(4 * llint_pkg::REG_POINT_COUNT)) ?
                    32'(point_count) : 32'd0;
  assign wr_item  = s_tvalid && s_tready && (s_tuser == llint_pkg::REQ_WRITE);
  assign pc_ext   = 7'(point_count);
  assign n        = (pc_ext > 7'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(point_count);

  assign c_q[0]    = q_reg;
  assign c_flo[0]  = '0;
  assign c_fhi[0]  = '0;
  assign c_lo[0]   = '0;
  assign c_hi[0]   = '0;
  assign c_mode[0] = llint_pkg::MODE_STEP;
  assign c_ctl[0]  = '0;

  for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
    llint_cell #(
      .FREQ_BITS (FREQ_BITS),
      .IS_FIRST  (j == 0)
    ) u_cell (
      .clk      (clk),
      .wr_en    (wr_item && (32'(s_tdata[F_IDX +: 4]) == j)),
      .wr_freq  (s_tdata[F_FREQ +: FREQ_BITS]),
      .wr_level (s_tdata[F_LVL +: LV]),
      .wr_mode  (s_tdata[F_MODE +: llint_pkg::MODE_W]),
      .active   (NW'(j) < n),
      .is_last  (NW'(j + 1) == n),
      .in_q     (c_q[j]),
      .in_flo   (c_flo[j]),
      .in_fhi   (c_fhi[j]),
      .in_lo    (c_lo[j]),
      .in_hi    (c_hi[j]),
      .in_mode  (c_mode[j]),
      .in_ctl   (c_ctl[j]),
      .out_q    (c_q[j+1]),
      .out_flo  (c_flo[j+1]),
      .out_fhi  (c_fhi[j+1]),
      .out_lo   (c_lo[j+1]),
      .out_hi   (c_hi[j+1]),
      .out_mode (c_mode[j+1]),
      .out_ctl  (c_ctl[j+1])
    );
  end

  llint_log #(
    .FREQ_BITS (FREQ_BITS),
    .EW        (EW)
  ) u_log (
    .clk    (clk),
    .rst    (rst),
    .go     (log_go),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  llint_div #(
    .NW (SPW + llint_pkg::LOG_FRAC),
    .DW (SPW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend ({num, 16'd0}),
    .divisor  (span),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign diff = {hi_r[LV-1], hi_r} - {lo_r[LV-1], lo_r};
  assign sum  = {{4{lo_r[LV-1]}}, lo_r} + {prod[34], prod[34:16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      log_go      <= 1'b0;
      div_go      <= 1'b0;
      point_count <= '0;
    end else begin
      log_go <= 1'b0;
      div_go <= 1'b0;
      if (psel && penable && pwrite &&
          paddr == 3'(4 * llint_pkg::REG_POINT_COUNT)) begin
        point_count <= pwdata[llint_pkg::PC_W-1:0];
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tuser == llint_pkg::REQ_EVAL) begin
            q_reg <= s_tdata[F_Q +: FREQ_BITS];
            cnt   <= '0;
            state <= S_CHAIN;
          end
        end
        S_CHAIN: begin
          cnt <= cnt + 1'b1;
          if (cnt == NW'(MAX_POINTS)) begin
            flo_r <= c_flo[MAX_POINTS];
            fhi_r <= c_fhi[MAX_POINTS];
            lo_r  <= c_lo[MAX_POINTS];
            hi_r  <= c_hi[MAX_POINTS];
            if (n == '0 || c_ctl[MAX_POINTS].below || c_ctl[MAX_POINTS].above) begin
              m_tdata  <= '0;
              m_tuser  <= 1'b0;
              m_tvalid <= 1'b1;
              state    <= S_OUT;
            end else if (!c_ctl[MAX_POINTS].hi_found ||
                         (c_mode[MAX_POINTS] != llint_pkg::MODE_LOG &&
                          c_mode[MAX_POINTS] != llint_pkg::MODE_LIN) ||
                         (c_mode[MAX_POINTS] == llint_pkg::MODE_LIN &&
                          c_fhi[MAX_POINTS] <= c_flo[MAX_POINTS]) ||
                         (c_mode[MAX_POINTS] == llint_pkg::MODE_LOG &&
                          (c_flo[MAX_POINTS] == '0 || c_fhi[MAX_POINTS] == '0 ||
                           q_reg == '0))) begin
              m_tdata  <= c_lo[MAX_POINTS];
              m_tuser  <= 1'b1;
              m_tvalid <= 1'b1;
              state    <= S_OUT;
            end else if (c_mode[MAX_POINTS] == llint_pkg::MODE_LIN) begin
              num    <= SPW'(q_reg - c_flo[MAX_POINTS]);
              span   <= SPW'(c_fhi[MAX_POINTS] - c_flo[MAX_POINTS]);
              div_go <= 1'b1;
              state  <= S_DIV;
            end else begin
              log_x  <= c_flo[MAX_POINTS];
              log_go <= 1'b1;
              state  <= S_LLO;
            end
          end
        end
        S_LLO: begin
          if (log_done) begin
            llo    <= log_res;
            log_x  <= fhi_r;
            log_go <= 1'b1;
            state  <= S_LHI;
          end
        end
        S_LHI: begin
          if (log_done) begin
            lhi    <= log_res;
            log_x  <= q_reg;
            log_go <= 1'b1;
            state  <= S_LQ;
          end
        end
        S_LQ: begin
          if (log_done) begin
            if (lhi <= llo) begin
              m_tdata  <= lo_r;
              m_tuser  <= 1'b1;
              m_tvalid <= 1'b1;
              state    <= S_OUT;
            end else begin
              num    <= (log_res > llo) ? SPW'(log_res - llo) : '0;
              span   <= SPW'(lhi - llo);
              div_go <= 1'b1;
              state  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            frac  <= div_quot;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= $signed({1'b0, frac}) * diff;
          state <= S_SUM;
        end
        S_SUM: begin
          if (sum > 20'sd32767) begin
            m_tdata <= 16'h7fff;
          end else if (sum < -20'sd32768) begin
            m_tdata <= 16'h8000;
          end else begin
            m_tdata <= sum[15:0];
          end
          m_tuser  <= 1'b1;
          m_tvalid <= 1'b1;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == S_OUT)
    else $error("result shown outside the output state");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  a_uncovered_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tdata == 16'd0)
    else $error("uncovered result carries a nonzero level");

  a_eval_starts_chain: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == llint_pkg::REQ_EVAL) |=> state == S_CHAIN)
    else $error("evaluation did not enter the cell chain");

endmodule

>>> rtl/llint_cell.sv
// ----------------------------------------------------------------------------
// Limit-line cell
// Holds one breakpoint and updates the segment token passing through it.
// ----------------------------------------------------------------------------
module llint_cell #(
  parameter int FREQ_BITS = 34,
  parameter bit IS_FIRST  = 1'b0
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [FREQ_BITS-1:0]                wr_freq,
  input  logic signed [llint_pkg::LEVEL_W-1:0] wr_level,
  input  logic [llint_pkg::MODE_W-1:0]        wr_mode,
  input  logic                                active,
  input  logic                                is_last,
  input  logic [FREQ_BITS-1:0]                in_q,
  input  logic [FREQ_BITS-1:0]                in_flo,
  input  logic [FREQ_BITS-1:0]                in_fhi,
  input  logic signed [llint_pkg::LEVEL_W-1:0] in_lo,
  input  logic signed [llint_pkg::LEVEL_W-1:0] in_hi,
  input  logic [llint_pkg::MODE_W-1:0]        in_mode,
  input  llint_pkg::chain_ctl_t               in_ctl,
  output logic [FREQ_BITS-1:0]                out_q,
  output logic [FREQ_BITS-1:0]                out_flo,
  output logic [FREQ_BITS-1:0]                out_fhi,
  output logic signed [llint_pkg::LEVEL_W-1:0] out_lo,
  output logic signed [llint_pkg::LEVEL_W-1:0] out_hi,
  output logic [llint_pkg::MODE_W-1:0]        out_mode,
  output llint_pkg::chain_ctl_t               out_ctl
);

  logic [FREQ_BITS-1:0]                freq;
  logic signed [llint_pkg::LEVEL_W-1:0] level;
  logic [llint_pkg::MODE_W-1:0]        mode;
  logic                                at_or_below;

  assign at_or_below = (freq <= in_q);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      freq  <= wr_freq;
      level <= wr_level;
      mode  <= wr_mode;
    end
  end

  always_ff @(posedge clk) begin
    out_q    <= in_q;
    out_flo  <= in_flo;
    out_fhi  <= in_fhi;
    out_lo   <= in_lo;
    out_hi   <= in_hi;
    out_mode <= in_mode;
    out_ctl  <= in_ctl;
    if (active && is_last && !at_or_below) begin
      out_ctl.above <= 1'b0;
    end
    if (active && is_last && (in_q > freq)) begin
      out_ctl.above <= 1'b1;
    end
    // The search stops at the first breakpoint above the query.
    if (active && !in_ctl.hi_found) begin
      if (at_or_below) begin
        out_flo  <= freq;
        out_lo   <= level;
        out_mode <= mode;
      end else if (IS_FIRST) begin
        out_ctl.below <= 1'b1;
      end else begin
        out_ctl.hi_found <= 1'b1;
        out_fhi          <= freq;
        out_hi           <= level;
      end
    end
  end

endmodule

>>> rtl/llint_log.sv
// ----------------------------------------------------------------------------
// Log2 unit
// Normalizes by one shift a cycle, then squares the mantissa 16 times.
// ----------------------------------------------------------------------------
module llint_log #(
  parameter int FREQ_BITS = 34,
  parameter int EW        = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  logic [FREQ_BITS-1:0]               x,
  output logic                               done,
  output logic [EW+llint_pkg::LOG_FRAC-1:0]  result
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_MUL, L_CHK} lstate_t;

  lstate_t                        state;
  logic [FREQ_BITS-1:0]           xn;
  logic [EW-1:0]                  e;
  logic [30:0]                    y;
  logic [61:0]                    prod;
  logic [llint_pkg::LOG_FRAC-1:0] bits;
  logic [3:0]                     cnt;
  logic [FREQ_BITS+30:0]          wide;
  logic [31:0]                    sq;

  assign wide   = {xn, 31'b0};
  assign sq     = prod[61:30];
  assign result = {e, bits};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (go) begin
            xn    <= x;
            e     <= EW'(FREQ_BITS - 1);
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (xn[FREQ_BITS-1]) begin
            y     <= wide[FREQ_BITS+30 -: 31];
            bits  <= '0;
            cnt   <= '0;
            state <= L_MUL;
          end else begin
            xn <= {xn[FREQ_BITS-2:0], 1'b0};
            e  <= e - 1'b1;
          end
        end
        L_MUL: begin
          prod  <= 62'(y * y);
          state <= L_CHK;
        end
        L_CHK: begin
          if (sq[31]) begin
            y    <= sq[31:1];
            bits <= {bits[llint_pkg::LOG_FRAC-2:0], 1'b1};
          end else begin
            y    <= sq[30:0];
            bits <= {bits[llint_pkg::LOG_FRAC-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 4'd15) begin
            done  <= 1'b1;
            state <= L_IDLE;
          end else begin
            state <= L_MUL;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/llint_div.sv
// ----------------------------------------------------------------------------
// Segment fraction divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module llint_div #(
  parameter int NW = 50,
  parameter int DW = 34
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic [NW-1:0]                    dividend,
  input  logic [DW-1:0]                    divisor,
  output logic                             done,
  output logic [llint_pkg::FRAC_W-1:0]     quot
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] dvd;
  logic [DW-1:0] dsr;
  logic [DW-1:0] rem;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;

  assign rem_sh = {rem, dvd[NW-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign quot   = dvd[llint_pkg::FRAC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= CW'(NW);
      end else if (busy) begin
        if (!diff[DW]) begin
          rem <= diff[DW-1:0];
          dvd <= {dvd[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DW-1:0];
          dvd <= {dvd[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> dv/tb_limit_line_interpolator.sv
// ----------------------------------------------------------------------------
// Limit-line interpolator testbench
// Loads breakpoint tables through the input stream, sets point_count over APB
// and checks every evaluation against a predictor of the log, linear and step
// interpolation, with random gaps and stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_limit_line_interpolator;

  localparam int NPTS   = 16;
  localparam int FBITS  = 34;
  localparam int TDATA_W = ((2*FBITS+22+7)/8)*8;
  localparam longint unsigned FMASK = (64'd1 << FBITS) - 1;
  localparam int DRAIN_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 1500;

  typedef struct {
    logic [15:0] level;
    logic        covered;
  } limit_result_t;

  class limit_scoreboard;
    limit_result_t pending[$];
    int errors = 0;
    int checked = 0;
    int evals = 0;

    function void note_eval(logic [15:0] level, logic covered);
      limit_result_t r;
      r.level = level;
      r.covered = covered;
      pending.push_back(r);
      evals++;
    endfunction

    function void check(logic [15:0] level, logic covered);
      limit_result_t r;
      if (pending.size() == 0) begin
        $error("result with no evaluation pending: level %h covered %b", level, covered);
        errors++;
        return;
      end
      r = pending.pop_front();
      checked++;
      if (level !== r.level) begin
        $error("limit_level expected %h actual %h", r.level, level);
        errors++;
      end
      if (covered !== r.covered) begin
        $error("covered expected %b actual %b", r.covered, covered);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  limit_line_interpolator #(.MAX_POINTS(NPTS), .FREQ_BITS(FBITS)) dut (.*);

  always #1 clk = ~clk;

  limit_scoreboard sb = new();

  // Predictor copy of the table and the register.
  longint unsigned tbl_freq [NPTS];
  int              tbl_level[NPTS];
  logic [1:0]      tbl_mode [NPTS];
  int unsigned     pc_value = 0;

  bit no_idle = 0;
  bit long_hold_req = 0;
  int idle_cycles = 0;
  int write_items = 0;

  function automatic longint unsigned log2_q16(longint unsigned x);
    int e;
    longint unsigned y;
    longint unsigned bits;
    e = 0;
    bits = 0;
    for (int i = 0; i < 64; i++) if (x[i]) e = i;
    y = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 0; i < llint_pkg::LOG_FRAC; i++) begin
      y = (y * y) >> 30;
      bits = bits << 1;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        bits = bits | 1;
      end
    end
    return (longint'(e) << llint_pkg::LOG_FRAC) | bits;
  endfunction

  function automatic int blend_level(int lo, int hi, longint unsigned frac);
    longint p;
    longint v;
    p = longint'(frac) * longint'(hi - lo);
    v = longint'(lo) + (p >>> llint_pkg::LOG_FRAC);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return int'(v);
  endfunction

  function automatic int segment_level(int k, longint unsigned q);
    longint unsigned flo, fhi, llo, lhi, lq, num;
    flo = tbl_freq[k];
    fhi = tbl_freq[k+1];
    if (tbl_mode[k] == llint_pkg::MODE_LIN) begin
      if (fhi <= flo || q < flo) return tbl_level[k];
      return blend_level(tbl_level[k], tbl_level[k+1],
                         ((q - flo) << llint_pkg::LOG_FRAC) / (fhi - flo));
    end
    if (tbl_mode[k] == llint_pkg::MODE_LOG) begin
      if (flo == 0 || fhi == 0 || q == 0) return tbl_level[k];
      llo = log2_q16(flo);
      lhi = log2_q16(fhi);
      if (lhi <= llo) return tbl_level[k];
      lq = log2_q16(q);
      num = (lq > llo) ? (lq - llo) : 0;
      return blend_level(tbl_level[k], tbl_level[k+1],
                         (num << llint_pkg::LOG_FRAC) / (lhi - llo));
    end
    // Step and the unused fourth mode hold the lower amplitude.
    return tbl_level[k];
  endfunction

  function automatic void predict_limit(longint unsigned q_in);
    int n, k, lvl;
    longint unsigned q;
    n = (pc_value > NPTS) ? NPTS : pc_value;
    q = q_in & FMASK;
    if (n == 0 || q < tbl_freq[0] || q > tbl_freq[n-1]) begin
      sb.note_eval(16'h0, 1'b0);
      return;
    end
    k = 0;
    for (int i = 0; i + 1 < n; i++) begin
      if (tbl_freq[i+1] <= q) k = i + 1;
      else break;
    end
    lvl = (k + 1 >= n) ? tbl_level[n-1] : segment_level(k, q);
    sb.note_eval(lvl[15:0], 1'b1);
  endfunction

  function automatic longint unsigned rand_freq();
    return {$urandom, $urandom} & FMASK;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(logic kind, logic [3:0] idx, longint unsigned freq,
                           logic [15:0] lvl, logic [1:0] mode, longint unsigned q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser <= kind;
    s_tdata <= {6'b0, q[FBITS-1:0], mode, lvl, freq[FBITS-1:0], idx};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (kind == llint_pkg::REQ_WRITE) begin
      tbl_freq[idx] = freq & FMASK;
      tbl_level[idx] = $signed(lvl);
      tbl_mode[idx] = mode;
      write_items++;
    end else begin
      predict_limit(q);
    end
  endtask

  task automatic write_entry(int idx, longint unsigned freq, int lvl, int mode);
    send_item(llint_pkg::REQ_WRITE, idx[3:0], freq, lvl[15:0], mode[1:0],
              64'($urandom_range(1, 1000)));
  endtask

  task automatic eval_at(longint unsigned q);
    send_item(llint_pkg::REQ_EVAL, 4'($urandom_range(0, 15)), rand_freq(),
              16'($urandom), 2'($urandom_range(0, 3)), q);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    wait (sb.pending.size() == 0);
    // Writes leave no result, so let any trailing work finish.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_point_count(int unsigned value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * llint_pkg::REG_POINT_COUNT);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pc_value = value & 31;
  endtask

  // Fills all sixteen slots; kind 0 sorted, 1 full-range sorted, 2 unsorted.
  task automatic load_table(int kind);
    longint unsigned f;
    longint unsigned step;
    int lvl;
    f = (kind == 1) ? 1 : $urandom_range(1, 1 << 20);
    for (int i = 0; i < NPTS; i++) begin
      if (kind == 2) f = rand_freq() | 1;
      else if (kind == 1 && i == NPTS - 1) f = FMASK;
      else if (i > 0) begin
        step = ($urandom_range(0, 9) == 0) ? 0 : (rand_freq() >> $urandom_range(4, 33));
        f = (f + step > FMASK) ? FMASK : f + step;
      end
      case ($urandom_range(0, 5))
        0: lvl = -32768;
        1: lvl = 32767;
        default: lvl = $signed(16'($urandom));
      endcase
      write_entry(i, f, lvl, $urandom_range(0, 3));
    end
  endtask

  task automatic random_query();
    int n;
    int r;
    longint unsigned lo, hi;
    n = (pc_value > NPTS) ? NPTS : pc_value;
    r = $urandom_range(0, 99);
    if (n == 0 || r < 15) begin
      eval_at(rand_freq() | 1);
      return;
    end
    lo = tbl_freq[0];
    hi = tbl_freq[n-1];
    if (r < 30) eval_at(tbl_freq[$urandom_range(0, n - 1)]);
    else if (r < 40) eval_at((tbl_freq[$urandom_range(0, n - 1)] + 1) & FMASK | 1);
    else if (r < 45 && lo > 1) eval_at(lo - 1);
    else if (r < 50 && hi < FMASK) eval_at(hi + 1);
    else if (hi >= lo) eval_at(lo + (rand_freq() % (hi - lo + 1)));
    else eval_at(rand_freq() | 1);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random backpressure, plus one long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 0;
        m_tready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0) m_tready <= 1'b1;
        else begin
          m_tready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned settings[10] = '{16, 0, 1, 2, 5, 16, 31, 20, 9, 16};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full-range table with extreme levels and every mode.
    set_point_count(16);
    write_entry(0, 1, -32768, int'(llint_pkg::MODE_LOG));
    write_entry(1, 1000, 32767, int'(llint_pkg::MODE_LIN));
    write_entry(2, 2000, -32768, int'(llint_pkg::MODE_STEP));
    write_entry(3, 3000, 100, 3);
    write_entry(4, 3000, -100, int'(llint_pkg::MODE_LIN));
    for (int i = 5; i < NPTS - 1; i++) write_entry(i, 64'd1 << (i + 13), i * 997 - 8000, i % 3);
    write_entry(NPTS - 1, FMASK, 32767, int'(llint_pkg::MODE_LOG));
    eval_at(1);
    eval_at(500);
    eval_at(1500);
    eval_at(2500);
    eval_at(3000);
    eval_at(FMASK - 1);
    eval_at(FMASK);
    eval_at(64'd3 << 20);

    for (int ph = 0; ph < 10; ph++) begin
      no_idle = (ph == 3 || ph == 7);
      set_point_count(settings[ph]);
      load_table((ph == 6) ? 2 : ((ph % 4 == 1) ? 1 : 0));
      for (int j = 0; j < 36; j++) begin
        if (ph == 4 && j == 5) long_hold_req = 1;
        if (ph == 5 && j == 18) begin
          // The sender stops offering while the results drain.
          s_tvalid <= 1'b0;
          wait (sb.pending.size() == 0);
        end
        random_query();
      end
    end
    no_idle = 0;

    wait_drained();
    $display("Covered %0d table writes and %0d evaluations (%0d results checked)",
             write_items, sb.evals, sb.checked);
    $display("over point counts 0 to 31, sorted, full-range and unsorted tables.");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
